### rtl/apd_pkg.sv
// Package for the addressed packet deframer.
// Holds the framing characters, buffer sizing, and the state and kind types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apd_pkg;

	localparam int PACKET_CAPACITY = 64;
	localparam int IDX_W = $clog2(PACKET_CAPACITY);
	localparam int CNT_W = $clog2(PACKET_CAPACITY + 1);

	localparam logic [7:0] SOH = 8'h01;
	localparam logic [7:0] EOT = 8'h04;
	localparam logic [7:0] ENQ = 8'h05;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_ADDR,
		ST_COLLECT,
		ST_DISCARD,
		ST_REPLAY
	} state_t;

	typedef enum logic [1:0] {
		KIND_ADDRESSED = 2'd0,
		KIND_BEACON    = 2'd1,
		KIND_OVERFLOW  = 2'd2
	} kind_t;

endpackage

`default_nettype wire

### rtl/apd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the packet store of the deframer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module apd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/addressed_packet_deframer_unit.sv
// Top level of the addressed packet deframer.
// Depends on apd_pkg and on apd_ram for the packet store.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one received byte per cycle while it hunts for SOH, checks the
// address byte and collects a packet, unless the buffer is full and the output busy.
// When EOT arrives the packet of N bytes is replayed from the packet store, one RAM
// read per cycle while the output takes them, and the input is held off until the
// last byte is loaded for output. A byte that overflows the buffer gives one
// overflow transfer at once. The store needs no clearing after reset.
module addressed_packet_deframer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // rx_byte[7:0]
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata,  // pkt_byte[7:0]
	output logic      [1:0] m_axis_tuser,  // pkt_kind[1:0]
	output logic            m_axis_tlast,  // last_byte
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data    // device_name[7:0]
);

	import apd_pkg::*;

	state_t            state_q, state_d;
	logic [7:0]        device_name_q;
	logic              is_beacon_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              rd_pend_s1;
	logic              rd_last_s1;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	kind_t             out_kind_q;
	logic              out_last_q;

	logic              in_acc;
	logic              full;
	logic              out_free;
	logic              load;
	logic              issue;
	logic              ovf;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [7:0]        ram_rdata;
	logic              addr_ok;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign full     = (cnt_q == CNT_W'(PACKET_CAPACITY));
	assign out_free = !out_valid_q || m_axis_tready;
	assign load     = rd_pend_s1 && out_free;
	assign issue    = (state_q == ST_REPLAY) && (rd_idx_q != cnt_q) && (!rd_pend_s1 || load);
	assign addr_ok  = (s_axis_tdata == device_name_q) || (s_axis_tdata == ENQ);
	assign ovf      = in_acc && (state_q == ST_COLLECT) && full;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b1;
		ram_we        = 1'b0;
		ram_waddr     = '0;
		case (state_q)
			ST_HUNT: begin
				ram_we = in_acc && (s_axis_tdata == SOH);
				if (in_acc && s_axis_tdata == SOH) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				ram_we    = in_acc && addr_ok;
				ram_waddr = IDX_W'(1);
				if (in_acc) begin
					state_d = addr_ok ? ST_COLLECT : ST_HUNT;
				end
			end
			ST_COLLECT: begin
				s_axis_tready = !full || out_free;
				ram_we        = in_acc && !full;
				ram_waddr     = cnt_q[IDX_W-1:0];
				if (in_acc) begin
					if (full) begin
						state_d = (s_axis_tdata == EOT) ? ST_HUNT : ST_DISCARD;
					end else if (s_axis_tdata == EOT) begin
						state_d = ST_REPLAY;
					end
				end
			end
			ST_DISCARD: begin
				if (in_acc && s_axis_tdata == EOT) begin
					state_d = ST_HUNT;
				end
			end
			ST_REPLAY: begin
				s_axis_tready = 1'b0;
				if (rd_idx_q == cnt_q && (!rd_pend_s1 || load)) begin
					state_d = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_name_q <= '0;
			is_beacon_q   <= 1'b0;
			cnt_q         <= '0;
			rd_idx_q      <= '0;
			rd_pend_s1    <= 1'b0;
			rd_last_s1    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				device_name_q <= cfg_wr_data;
			end
			if (in_acc && state_q == ST_ADDR && addr_ok) begin
				is_beacon_q <= (s_axis_tdata != device_name_q);
				cnt_q       <= CNT_W'(2);
			end else if (in_acc && state_q == ST_COLLECT) begin
				cnt_q <= full ? '0 : cnt_q + CNT_W'(1);
			end else if (state_q == ST_REPLAY && state_d == ST_HUNT) begin
				cnt_q <= '0;
			end
			if (state_q != ST_REPLAY) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (issue) begin
				rd_pend_s1 <= 1'b1;
				rd_last_s1 <= (rd_idx_q == cnt_q - CNT_W'(1));
			end else if (load) begin
				rd_pend_s1 <= 1'b0;
			end
			if (load || ovf) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ovf) begin
			out_byte_q <= '0;
			out_kind_q <= KIND_OVERFLOW;
			out_last_q <= 1'b1;
		end else if (load) begin
			out_byte_q <= ram_rdata;
			out_kind_q <= is_beacon_q ? KIND_BEACON : KIND_ADDRESSED;
			out_last_q <= rd_last_s1;
		end
	end

	apd_ram #(
		.WIDTH(8),
		.DEPTH(PACKET_CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_axis_tdata),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_pend_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> state_q == ST_REPLAY)
		else $error("Packet store read pending outside replay.");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PACKET_CAPACITY))
		else $error("Fill count exceeds packet capacity.");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_OVERFLOW) |-> out_last_q)
		else $error("Overflow transfer not marked last.");

	a_replay_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLAY && state_d == ST_HUNT) |-> (load && rd_last_s1))
		else $error("Replay ended without delivering the last byte.");

	a_no_ovf_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ovf |-> !load)
		else $error("Overflow result collides with replay data.");

endmodule

`default_nettype wire

### dv/addressed_packet_deframer_unit_tb.sv
// Testbench for addressed_packet_deframer_unit: streams received bytes into the deframer,
// predicts every transfer, replayed packet bytes and overflow reports alike, and
// compares each one field by field. Depends on apd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module addressed_packet_deframer_unit_tb;
	import apd_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 80;

	typedef enum logic [1:0] {
		HUNT_SOH,
		WANT_ADDR,
		GATHER,
		SKIP_TO_EOT
	} parse_t;

	typedef struct {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} pkt_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tready = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	wire        s_axis_tready;
	wire        m_axis_tvalid;
	wire  [7:0] m_axis_tdata;
	wire  [1:0] m_axis_tuser;
	wire        m_axis_tlast;

	logic [7:0]  model_name = 8'h00;
	parse_t      model_phase = HUNT_SOH;
	logic        model_beacon = 1'b0;
	int          model_fill = 0;
	logic [7:0]  model_store [PACKET_CAPACITY];
	pkt_result_t expected_pkt [$];
	int          error_count = 0;
	int          useful_bytes = 0;
	int          cycle_count = 0;
	bit          idle_en = 1'b1;

	addressed_packet_deframer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("addressed_packet_deframer_unit_tb failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic queue_result(input logic [7:0] d, input kind_t k, input logic l);
		pkt_result_t r;
		r.data = d;
		r.kind = k;
		r.last = l;
		expected_pkt.push_back(r);
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		kind_t k;
		if (model_phase != HUNT_SOH || b == SOH)
			useful_bytes++;
		case (model_phase)
			HUNT_SOH: begin
				if (b == SOH)
					model_phase = WANT_ADDR;
			end
			WANT_ADDR: begin
				if (b == model_name || b == ENQ) begin
					model_beacon = (b != model_name);
					model_store[0] = SOH;
					model_store[1] = b;
					model_fill = 2;
					model_phase = GATHER;
				end else begin
					model_phase = HUNT_SOH;
				end
			end
			GATHER: begin
				if (model_fill >= PACKET_CAPACITY) begin
					// The whole packet is dropped and reported with a single transfer.
					queue_result(8'h00, KIND_OVERFLOW, 1'b1);
					model_fill = 0;
					model_phase = (b == EOT) ? HUNT_SOH : SKIP_TO_EOT;
				end else begin
					model_store[model_fill] = b;
					model_fill++;
					if (b == EOT) begin
						k = model_beacon ? KIND_BEACON : KIND_ADDRESSED;
						for (int i = 0; i < model_fill; i++)
							queue_result(model_store[i], k, i == model_fill - 1);
						model_fill = 0;
						model_phase = HUNT_SOH;
					end
				end
			end
			default: begin
				if (b == EOT)
					model_phase = HUNT_SOH;
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		deframe_byte(b);
	endtask

	function automatic logic [7:0] payload_byte();
		logic [7:0] v;
		v = 8'($urandom_range(0, 254));
		if (v >= EOT)
			v = v + 8'd1;
		return v;
	endfunction

	task automatic send_packet(input logic [7:0] addr, input int len);
		send_byte(SOH);
		send_byte(addr);
		repeat (len) send_byte(payload_byte());
		send_byte(EOT);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_pkt.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_device_name(input logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_name = v;
		@(posedge clk);
	endtask

	task automatic test_reset_name();
		send_byte(SOH);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(EOT);
		send_byte(SOH);
		send_byte(ENQ);
		send_byte(EOT);
		settle();
	endtask

	task automatic test_address_rules();
		set_device_name(ENQ);
		send_byte(SOH);
		send_byte(ENQ);
		send_byte(8'hFF);
		send_byte(EOT);
		settle();
		set_device_name(8'hA5);
		send_byte(SOH);
		send_byte(8'h33);
		send_byte(8'h10);
		send_byte(EOT);
		send_byte(SOH);
		send_byte(SOH);
		send_byte(8'h7E);
		send_byte(SOH);
		send_byte(8'hA5);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(EOT);
		settle();
	endtask

	task automatic test_capacity();
		set_device_name(8'hFF);
		send_packet(8'hFF, PACKET_CAPACITY - 3);
		send_packet(ENQ, PACKET_CAPACITY - 2);
		send_packet(8'hFF, PACKET_CAPACITY + 3);
		send_packet(ENQ, 1);
		settle();
	endtask

	task automatic test_random_traffic(input logic [7:0] name, input int n_items);
		int goal;
		int pick;
		int len;
		set_device_name(name);
		goal = useful_bytes + n_items;
		while (useful_bytes < goal) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PACKET_CAPACITY + 4)
				: $urandom_range(0, 10);
			if (pick < 60) begin
				send_packet(($urandom_range(0, 3) == 0) ? ENQ : model_name, len);
			end else if (pick < 75) begin
				send_packet(8'($urandom_range(0, 255)), $urandom_range(0, 4));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// A packet that never sees its EOT runs into whatever follows.
				send_byte(SOH);
				send_byte(model_name);
				repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
			end
		end
		settle();
	endtask

	initial begin
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (idle_en && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_result
		pkt_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pkt.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer data=%02h kind=%0d last=%0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end else begin
				want = expected_pkt.pop_front();
				if (m_axis_tdata !== want.data)
					report_mismatch($sformatf("pkt_byte %02h, expected %02h",
						m_axis_tdata, want.data));
				if (m_axis_tuser !== want.kind)
					report_mismatch($sformatf("pkt_kind %0d, expected %0d",
						m_axis_tuser, want.kind));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last_byte %0b, expected %0b",
						m_axis_tlast, want.last));
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_name();
		test_address_rules();
		test_capacity();
		test_random_traffic(8'($urandom_range(0, 255)), 40);
		test_random_traffic(8'h00, 40);
		test_random_traffic(8'hFF, 40);
		test_random_traffic(SOH, 40);
		test_random_traffic(EOT, 40);
		idle_en = 1'b0;
		test_random_traffic(8'($urandom_range(0, 255)), 40);
		if (error_count == 0) begin
			$display("addressed_packet_deframer_unit_tb passed");
		end else begin
			$display("addressed_packet_deframer_unit_tb failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/apd_pkg.sv
rtl/apd_ram.sv
rtl/addressed_packet_deframer_unit.sv
dv/addressed_packet_deframer_unit_tb.sv
